>>> rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int RCNT_W = 5;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LIST_ASC  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIST_DESC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_LIST,
    S_REMOVE,
    S_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROT_L,
    OP_ROT_R
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    logic occupied;
    logic head;
    logic tail;
  } cell_pos_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  element;
    logic                     last;
    logic [STAT_W-1:0]        status;
    logic [RCNT_W-1:0]        removed_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/sle_cell.sv
`default_nettype none

module sle_cell (
  input  wire logic                            clk,
  input  wire sle_pkg::cell_ctrl_t             ctrl,
  input  wire sle_pkg::cell_pos_t              pos,
  input  wire logic                            prev_gt,
  input  wire logic signed [sle_pkg::VAL_W-1:0] prev_val,
  input  wire logic signed [sle_pkg::VAL_W-1:0] next_val,
  input  wire logic signed [sle_pkg::VAL_W-1:0] head_val,
  input  wire logic signed [sle_pkg::VAL_W-1:0] tail_val,
  output logic signed [sle_pkg::VAL_W-1:0]      val,
  output logic                                  gt,
  output logic                                  eq
);

  logic signed [sle_pkg::VAL_W-1:0] val_r;
  logic signed [sle_pkg::VAL_W-1:0] val_nxt;

  assign val = val_r;
  // key sorts after this entry; in a sorted row this is a prefix
  assign gt  = pos.occupied && (ctrl.key > val_r);
  assign eq  = pos.occupied && (ctrl.key == val_r);

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      sle_pkg::OP_INSERT: begin
        // first cell not below the key takes it, later cells shift up
        if (!gt) begin
          val_nxt = prev_gt ? ctrl.key : prev_val;
        end
      end
      sle_pkg::OP_REMOVE: begin
        // drop the first match: everything from it onwards shifts down
        if (pos.occupied && !gt) begin
          val_nxt = next_val;
        end
      end
      sle_pkg::OP_ROT_L: begin
        if (pos.occupied) begin
          val_nxt = pos.tail ? head_val : next_val;
        end
      end
      sle_pkg::OP_ROT_R: begin
        if (pos.occupied) begin
          val_nxt = pos.head ? tail_val : prev_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_list_engine.sv
`default_nettype none

// Sorted list of up to DEPTH signed 32-bit values, held in a row of cells
// that each keep one entry and pass it to a neighbour. A command is taken
// when start is high and busy low; its results appear one per cycle on
// out_data with out_strobe and must be captured then, as they cannot be
// held off. Insert and clear give their beat through the command state
// and then the registered out_strobe. Remove shifts out one matching
// entry per cycle, then gives one result beat. A list command streams one
// entry a cycle by rotating the row, one beat per occupied entry (one
// EMPTY beat when empty). Unused command codes are dropped without a result.
module sorted_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sle_pkg::in_item_t  in_data,
  output logic                    out_strobe,
  output sle_pkg::out_item_t      out_data
);

  localparam int N = sle_pkg::DEPTH;
  localparam int CW = sle_pkg::CNT_W;

  sle_pkg::state_t    state_r, state_nxt;
  sle_pkg::in_item_t  cmd_r, cmd_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  sle_pkg::out_item_t out_data_r, out_data_nxt;

  sle_pkg::cell_ctrl_t             ctrl;
  logic signed [sle_pkg::VAL_W-1:0] vals [N];
  logic [N-1:0]                    gt_vec;
  logic [N-1:0]                    eq_vec;
  logic [N-1:0]                    tail_vec;
  logic signed [sle_pkg::VAL_W-1:0] tail_val;
  logic                            any_eq;
  logic                            accept;
  logic                            list_done;

  assign busy       = (state_r != sle_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign any_eq     = |eq_vec;
  assign list_done  = (occ_r == '0) || (idx_r == occ_r - CW'(1));

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    sle_pkg::cell_pos_t pos;

    assign pos.occupied = (CW'(i) < occ_r);
    assign pos.head     = (i == 0);
    assign pos.tail     = (CW'(i) == occ_r - CW'(1));
    assign tail_vec[i]  = pos.tail;

    sle_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (pos),
      .prev_gt  ((i == 0) ? 1'b1 : gt_vec[(i == 0) ? 0 : i - 1]),
      .prev_val (vals[(i == 0) ? 0 : i - 1]),
      .next_val (vals[(i == N - 1) ? N - 1 : i + 1]),
      .head_val (vals[0]),
      .tail_val (tail_val),
      .val      (vals[i]),
      .gt       (gt_vec[i]),
      .eq       (eq_vec[i])
    );
  end

  // last occupied entry, one-hot select
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < N; i++) begin
      tail_val = tail_val | (vals[i] & {sle_pkg::VAL_W{tail_vec[i]}});
    end
  end

  assign cmd_nxt = accept ? in_data : cmd_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sle_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            sle_pkg::KIND_INSERT:    state_nxt = sle_pkg::S_INSERT;
            sle_pkg::KIND_LIST_ASC:  state_nxt = sle_pkg::S_LIST;
            sle_pkg::KIND_LIST_DESC: state_nxt = sle_pkg::S_LIST;
            sle_pkg::KIND_REMOVE:    state_nxt = sle_pkg::S_REMOVE;
            sle_pkg::KIND_CLEAR:     state_nxt = sle_pkg::S_CLEAR;
            default:                 state_nxt = sle_pkg::S_IDLE;
          endcase
        end
      end
      sle_pkg::S_INSERT: state_nxt = sle_pkg::S_IDLE;
      sle_pkg::S_CLEAR:  state_nxt = sle_pkg::S_IDLE;
      sle_pkg::S_LIST: begin
        if (list_done) begin
          state_nxt = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_REMOVE: begin
        if (!any_eq) begin
          state_nxt = sle_pkg::S_IDLE;
        end
      end
      default: state_nxt = sle_pkg::S_IDLE;
    endcase
  end

  // datapath control and result beats
  always_comb begin
    ctrl.op        = sle_pkg::OP_HOLD;
    ctrl.key       = cmd_r.value;
    occ_nxt        = occ_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    case (state_r)
      sle_pkg::S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          idx_nxt = '0;
        end
      end
      sle_pkg::S_INSERT: begin
        out_strobe_nxt    = 1'b1;
        out_data_nxt.last = 1'b1;
        if (occ_r == CW'(N)) begin
          out_data_nxt.status = sle_pkg::STAT_FULL;
        end else begin
          ctrl.op             = sle_pkg::OP_INSERT;
          occ_nxt             = occ_r + CW'(1);
          out_data_nxt.status = sle_pkg::STAT_OK;
        end
      end
      sle_pkg::S_LIST: begin
        out_strobe_nxt = 1'b1;
        if (occ_r == '0) begin
          out_data_nxt.last   = 1'b1;
          out_data_nxt.status = sle_pkg::STAT_EMPTY;
        end else begin
          out_data_nxt.status = sle_pkg::STAT_OK;
          out_data_nxt.last   = list_done;
          idx_nxt             = idx_r + CW'(1);
          // a full turn of the occupied cells leaves the row as it was
          if (cmd_r.kind == sle_pkg::KIND_LIST_ASC) begin
            out_data_nxt.element = vals[0];
            ctrl.op              = sle_pkg::OP_ROT_L;
          end else begin
            out_data_nxt.element = tail_val;
            ctrl.op              = sle_pkg::OP_ROT_R;
          end
        end
      end
      sle_pkg::S_REMOVE: begin
        if (any_eq) begin
          // matches sit together, one leaves per cycle
          ctrl.op = sle_pkg::OP_REMOVE;
          occ_nxt = occ_r - CW'(1);
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          out_strobe_nxt             = 1'b1;
          out_data_nxt.last          = 1'b1;
          out_data_nxt.removed_count = sle_pkg::RCNT_W'(cnt_r);
          if (cnt_r != '0) begin
            out_data_nxt.status = sle_pkg::STAT_OK;
          end else if (occ_r == '0) begin
            out_data_nxt.status = sle_pkg::STAT_EMPTY;
          end else begin
            out_data_nxt.status = sle_pkg::STAT_NOTFOUND;
          end
        end
      end
      sle_pkg::S_CLEAR: begin
        out_strobe_nxt      = 1'b1;
        out_data_nxt.last   = 1'b1;
        out_data_nxt.status = (occ_r == '0) ? sle_pkg::STAT_EMPTY : sle_pkg::STAT_OK;
        occ_nxt             = '0;
      end
      default: begin
        ctrl.op = sle_pkg::OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sle_pkg::S_IDLE;
      occ_r        <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(N))
    else $error("occupancy beyond depth");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sle_pkg::S_INSERT && occ_r == CW'(N)) |=> occ_r == $past(occ_r))
    else $error("insert into full list changed occupancy");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sle_pkg::S_REMOVE) |=> occ_r <= $past(occ_r))
    else $error("remove grew the list");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !busy)
    else $error("final beat while still busy");

  a_stream_only_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |-> state_r == sle_pkg::S_LIST)
    else $error("non-final beat outside a list command");
`endif

endmodule

`default_nettype wire
